// ===== design/asp_pkg.sv =====
// Package for the aging slot pool: request codes, sequencer states,
// request/result structs and default sizes.
// No dependencies.
`default_nettype none

package asp_pkg;

  // Default sizes handed to the top level parameters
  localparam int POOL_SLOTS_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the request and result channels
  localparam int SLOT_W  = 6;
  localparam int LIFE_W  = 16;
  localparam int WORD_W  = 32;
  localparam int USED_W  = 7;

  // Request codes
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_READ,
    ST_DONE
  } asp_state_t;

  // Incoming request
  typedef struct packed {
    logic [1:0]        req_type;
    logic [LIFE_W-1:0] lifetime;
    logic [WORD_W-1:0] payload_x;
    logic [WORD_W-1:0] payload_y;
    logic [WORD_W-1:0] payload_scale;
    logic [SLOT_W-1:0] read_slot;
  } asp_in_t;

  // Outgoing result
  typedef struct packed {
    logic [SLOT_W-1:0] slot_used;
    logic              accepted;
    logic              live;
    logic [LIFE_W-1:0] remaining;
    logic [WORD_W-1:0] out_x;
    logic [WORD_W-1:0] out_y;
    logic [WORD_W-1:0] out_scale;
    logic [USED_W-1:0] used_count;
  } asp_out_t;

  // Sequencer status towards the output stage
  typedef struct packed {
    logic busy;
    logic res_vld;
  } asp_stat_t;

endpackage

`default_nettype wire

// ===== design/asp_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module asp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/asp_ctrl.sv =====
// Sequencer of the aging slot pool: add, tick walk, read and result forming.
// Depends on asp_pkg; drives the countdown, payload and free-list RAMs.
`default_nettype none

module asp_ctrl
  import asp_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire asp_in_t                       in_data,
  input  wire logic                          out_free,
  output asp_stat_t                          stat,
  output asp_out_t                           res,
  // countdown RAM
  output logic                               cnt_we,
  output logic [$clog2(POOL_SLOTS)-1:0]      cnt_waddr,
  output logic [COUNT_BITS-1:0]              cnt_wdata,
  output logic [$clog2(POOL_SLOTS)-1:0]      cnt_raddr,
  input  wire logic [COUNT_BITS-1:0]         cnt_rdata,
  // payload RAM
  output logic                               pay_we,
  output logic [$clog2(POOL_SLOTS)-1:0]      pay_waddr,
  output logic [3*WORD_W-1:0]                pay_wdata,
  output logic [$clog2(POOL_SLOTS)-1:0]      pay_raddr,
  input  wire logic [3*WORD_W-1:0]           pay_rdata,
  // free-list RAM
  output logic                               fifo_we,
  output logic [$clog2(POOL_SLOTS)-1:0]      fifo_waddr,
  output logic [$clog2(POOL_SLOTS)-1:0]      fifo_wdata,
  output logic [$clog2(POOL_SLOTS)-1:0]      fifo_raddr,
  input  wire logic [$clog2(POOL_SLOTS)-1:0] fifo_rdata
);

  localparam int SW   = $clog2(POOL_SLOTS);
  localparam int HW_W = $clog2(POOL_SLOTS + 1);
  localparam logic [HW_W-1:0] POOL_FULL = HW_W'(POOL_SLOTS);
  localparam logic [SW-1:0]   SLOT_LAST = SW'(POOL_SLOTS - 1);
  localparam logic [SW:0]     POOL_WRAP = (SW+1)'(POOL_SLOTS);

  asp_state_t      state_r, state_nxt;
  asp_in_t         req_r, req_nxt;
  asp_out_t        res_r, res_nxt;
  logic [HW_W-1:0] hw_r, hw_nxt;
  logic [HW_W-1:0] fcount_r, fcount_nxt;
  logic [SW-1:0]   fhead_r, fhead_nxt;
  logic [HW_W-1:0] idx_r, idx_nxt;
  logic            pv_r, pv_nxt;
  logic [SW-1:0]   pidx_r, pidx_nxt;
  logic            tick_end;

  // Walk finished once the index reached the high-water mark and the pipe drained
  assign tick_end = (idx_r >= hw_r) && !pv_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.req_type)
            REQ_ADD:  state_nxt = ST_ADD;
            REQ_TICK: state_nxt = ST_TICK;
            REQ_READ: state_nxt = ST_READ;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD:  state_nxt = ST_DONE;
      ST_READ: state_nxt = ST_DONE;
      ST_TICK: begin
        if (tick_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    logic [SW-1:0]         slot;
    logic                  take;
    logic [COUNT_BITS-1:0] dec;
    logic [SW:0]           tail_sum;
    logic                  in_bounds;

    req_nxt    = req_r;
    res_nxt    = res_r;
    hw_nxt     = hw_r;
    fcount_nxt = fcount_r;
    fhead_nxt  = fhead_r;
    idx_nxt    = idx_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;

    cnt_we     = 1'b0;
    cnt_waddr  = pidx_r;
    cnt_wdata  = '0;
    cnt_raddr  = SW'(in_data.read_slot);
    pay_we     = 1'b0;
    pay_waddr  = '0;
    pay_wdata  = {req_r.payload_x, req_r.payload_y, req_r.payload_scale};
    pay_raddr  = SW'(in_data.read_slot);
    fifo_we    = 1'b0;
    fifo_waddr = '0;
    fifo_wdata = pidx_r;
    fifo_raddr = fhead_r;

    slot      = '0;
    take      = 1'b0;
    dec       = cnt_rdata - COUNT_BITS'(1);
    tail_sum  = {1'b0, fhead_r} + (SW+1)'(fcount_r);
    in_bounds = 32'(req_r.read_slot) < 32'(hw_r);

    unique case (state_r)
      ST_IDLE: begin
        // Latch the request; unknown codes form their result at once
        pv_nxt  = 1'b0;
        idx_nxt = '0;
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          res_nxt.used_count = USED_W'(hw_r);
        end
      end

      ST_ADD: begin
        // Take the oldest freed slot, else append at the high-water mark
        if (fcount_r != '0) begin
          slot       = fifo_rdata;
          fhead_nxt  = (fhead_r == SLOT_LAST) ? '0 : fhead_r + SW'(1);
          fcount_nxt = fcount_r - HW_W'(1);
          take       = 1'b1;
        end else if (hw_r != POOL_FULL) begin
          slot   = hw_r[SW-1:0];
          hw_nxt = hw_r + HW_W'(1);
          take   = 1'b1;
        end
        res_nxt = '0;
        if (take) begin
          cnt_we    = 1'b1;
          cnt_waddr = slot;
          cnt_wdata = COUNT_BITS'(req_r.lifetime);
          pay_we    = 1'b1;
          pay_waddr = slot;
          res_nxt.slot_used = SLOT_W'(slot);
          res_nxt.accepted  = 1'b1;
        end
        res_nxt.used_count = USED_W'(hw_nxt);
      end

      ST_TICK: begin
        // Issue the read of the next slot
        if (idx_r < hw_r) begin
          cnt_raddr = idx_r[SW-1:0];
          pv_nxt    = 1'b1;
          pidx_nxt  = idx_r[SW-1:0];
          idx_nxt   = idx_r + HW_W'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        // Decrement the slot read last cycle, queue it when it runs out
        if (pv_r && (cnt_rdata != '0)) begin
          cnt_we    = 1'b1;
          cnt_waddr = pidx_r;
          cnt_wdata = dec;
          if ((dec == '0) && (fcount_r != POOL_FULL)) begin
            fifo_we    = 1'b1;
            fifo_waddr = (tail_sum >= POOL_WRAP) ? SW'(tail_sum - POOL_WRAP)
                                                 : tail_sum[SW-1:0];
            fcount_nxt = fcount_r + HW_W'(1);
          end
        end
        // Empty the pool once every used slot is free
        if (tick_end) begin
          if (fcount_r == hw_r) begin
            hw_nxt     = '0;
            fcount_nxt = '0;
            fhead_nxt  = '0;
          end
          res_nxt = '0;
          res_nxt.accepted   = 1'b1;
          res_nxt.used_count = USED_W'(hw_nxt);
        end
      end

      ST_READ: begin
        // Show the slot only below the high-water mark
        res_nxt = '0;
        res_nxt.slot_used  = req_r.read_slot;
        res_nxt.accepted   = 1'b1;
        res_nxt.used_count = USED_W'(hw_r);
        if (in_bounds) begin
          res_nxt.live      = (cnt_rdata != '0);
          res_nxt.remaining = LIFE_W'(cnt_rdata);
          res_nxt.out_x     = pay_rdata[3*WORD_W-1:2*WORD_W];
          res_nxt.out_y     = pay_rdata[2*WORD_W-1:WORD_W];
          res_nxt.out_scale = pay_rdata[WORD_W-1:0];
        end
      end

      ST_DONE: begin
        pv_nxt = 1'b0;
      end

      default: begin
        pv_nxt = 1'b0;
      end
    endcase
  end

  // Status outputs
  assign stat.busy    = (state_r != ST_IDLE);
  assign stat.res_vld = (state_r == ST_DONE);
  assign res          = res_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hw_r     <= '0;
      fcount_r <= '0;
      fhead_r  <= '0;
      idx_r    <= '0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hw_r     <= hw_nxt;
      fcount_r <= fcount_nxt;
      fhead_r  <= fhead_nxt;
      idx_r    <= idx_nxt;
      pv_r     <= pv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    pidx_r <= pidx_nxt;
  end

endmodule

`default_nettype wire

// ===== design/aging_slot_pool.sv =====
// Aging slot pool: add and read pass through their ST_ADD or ST_READ state, an unknown
// code goes straight to ST_DONE, and a tick walks one slot per cycle through the
// countdown RAM port up to the high-water mark (an empty pool goes straight to ST_DONE).
// out_valid rises once ST_DONE hands the result to the output register; the next
// request is taken in the cycle after the result enters the output register, and
// a stalled output holds the sequencer. Sync active-low reset clears pool and handshake.
`default_nettype none

module aging_slot_pool
  import asp_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire asp_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output asp_out_t     out_data
);

  localparam int SW = $clog2(POOL_SLOTS);

  asp_stat_t             stat;
  asp_out_t              res;
  logic                  out_free;
  logic                  out_valid_r;
  asp_out_t              out_data_r;

  logic                  cnt_we;
  logic [SW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [SW-1:0]         cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  pay_we;
  logic [SW-1:0]         pay_waddr;
  logic [3*WORD_W-1:0]   pay_wdata;
  logic [SW-1:0]         pay_raddr;
  logic [3*WORD_W-1:0]   pay_rdata;
  logic                  fifo_we;
  logic [SW-1:0]         fifo_waddr;
  logic [SW-1:0]         fifo_wdata;
  logic [SW-1:0]         fifo_raddr;
  logic [SW-1:0]         fifo_rdata;

  asp_ctrl #(
    .POOL_SLOTS (POOL_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .out_free   (out_free),
    .stat       (stat),
    .res        (res),
    .cnt_we     (cnt_we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata),
    .pay_we     (pay_we),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .pay_raddr  (pay_raddr),
    .pay_rdata  (pay_rdata),
    .fifo_we    (fifo_we),
    .fifo_waddr (fifo_waddr),
    .fifo_wdata (fifo_wdata),
    .fifo_raddr (fifo_raddr),
    .fifo_rdata (fifo_rdata)
  );

  asp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (POOL_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  asp_ram #(
    .WIDTH (3 * WORD_W),
    .DEPTH (POOL_SLOTS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  asp_ram #(
    .WIDTH (SW),
    .DEPTH (POOL_SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  // Hold off new requests while the sequencer works
  assign in_stall = stat.busy;

  // Output register frees when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_vld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_vld && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/asp_checker.sv =====
// Checker for the aging slot pool: watches both channels, keeps its own copy of the
// pool state, predicts each result and compares it field by field.
// Depends on asp_pkg for the request and result structs and the request codes.
`default_nettype none

module asp_checker
  import asp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire asp_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire asp_out_t out_data,
  output int            pending,
  output int            pool_used,
  output int            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = POOL_SLOTS_DEF;
  localparam int EXP_DEPTH = 8;

  // Shadow of the pool
  logic [LIFE_W-1:0] life_left [SLOTS];
  logic [WORD_W-1:0] word_x    [SLOTS];
  logic [WORD_W-1:0] word_y    [SLOTS];
  logic [WORD_W-1:0] word_s    [SLOTS];
  logic [SLOT_W-1:0] free_ring [SLOTS];
  int                hw_mark;
  int                free_cnt;
  int                free_rd;

  // Expected results, oldest at exp_rd
  asp_out_t exp_ring [EXP_DEPTH];
  int       exp_rd;
  int       exp_cnt;
  int       errs = 0;

  // Walk the used slots, count down, queue the ones that expire
  function automatic void age_pool();
    int i;
    for (i = 0; i < hw_mark; i++) begin
      if (life_left[i] != '0) begin
        life_left[i] = life_left[i] - 1'b1;
        if (life_left[i] == '0 && free_cnt < SLOTS) begin
          free_ring[(free_rd + free_cnt) % SLOTS] = SLOT_W'(i);
          free_cnt++;
        end
      end
    end
    // every used slot free again: empty the pool
    if (free_cnt == hw_mark) begin
      free_cnt = 0;
      hw_mark  = 0;
      free_rd  = 0;
    end
  endfunction

  // Apply one request to the shadow pool and return the result it should give
  function automatic asp_out_t pool_predict(asp_in_t rq);
    asp_out_t r;
    int       slot;
    r = '0;
    case (rq.req_type)
      REQ_ADD: begin
        slot = -1;
        if (free_cnt > 0) begin
          slot    = free_ring[free_rd];
          free_rd = (free_rd + 1) % SLOTS;
          free_cnt--;
        end else if (hw_mark < SLOTS) begin
          slot = hw_mark;
          hw_mark++;
        end
        if (slot >= 0) begin
          life_left[slot] = rq.lifetime;
          word_x[slot]    = rq.payload_x;
          word_y[slot]    = rq.payload_y;
          word_s[slot]    = rq.payload_scale;
          r.slot_used     = SLOT_W'(slot);
          r.accepted      = 1'b1;
        end
      end
      REQ_TICK: begin
        age_pool();
        r.accepted = 1'b1;
      end
      REQ_READ: begin
        slot        = rq.read_slot;
        r.slot_used = rq.read_slot;
        r.accepted  = 1'b1;
        if (slot < hw_mark) begin
          r.live      = (life_left[slot] != '0);
          r.remaining = life_left[slot];
          r.out_x     = word_x[slot];
          r.out_y     = word_y[slot];
          r.out_scale = word_s[slot];
        end
      end
      default: ;
    endcase
    r.used_count = USED_W'(hw_mark);
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Take the oldest expectation on each result, queue one on each request
  always @(posedge clk) begin : monitor
    asp_out_t want;
    if (!rst_n) begin
      hw_mark  = 0;
      free_cnt = 0;
      free_rd  = 0;
      exp_rd   = 0;
      exp_cnt  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_cnt == 0) begin
          $error("result arrived with no request outstanding");
          errs++;
        end else begin
          want    = exp_ring[exp_rd];
          exp_rd  = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt--;
          errs += field_diff("slot_used", 32'(want.slot_used), 32'(out_data.slot_used));
          errs += field_diff("accepted", 32'(want.accepted), 32'(out_data.accepted));
          errs += field_diff("live", 32'(want.live), 32'(out_data.live));
          errs += field_diff("remaining", 32'(want.remaining), 32'(out_data.remaining));
          errs += field_diff("out_x", want.out_x, out_data.out_x);
          errs += field_diff("out_y", want.out_y, out_data.out_y);
          errs += field_diff("out_scale", want.out_scale, out_data.out_scale);
          errs += field_diff("used_count", 32'(want.used_count),
                             32'(out_data.used_count));
        end
      end
      if (in_valid && !in_stall) begin
        if (exp_cnt == EXP_DEPTH) begin
          $error("more requests outstanding than the checker can hold");
          errs++;
        end else begin
          exp_ring[(exp_rd + exp_cnt) % EXP_DEPTH] = pool_predict(in_data);
          exp_cnt++;
        end
      end
    end
    pending    <= exp_cnt;
    pool_used  <= hw_mark;
    fail_count <= errs;
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the aging slot pool testbench: clock, reset, request stimulus, result stall
// and the verdict. Depends on asp_pkg, aging_slot_pool and asp_checker.
`default_nettype none

module tb
  import asp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_BAD   = 2'd3;   // code with no meaning
  localparam int         ITEMS     = 950;
  localparam int         TAIL_REQS = 100;
  localparam int         CYCLE_LIMIT = 1000000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  asp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  asp_out_t out_data;

  int pending;
  int pool_used;
  int fail_count;
  int sent      = 0;
  int cycle_cnt = 0;
  bit no_gaps   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aging_slot_pool dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  asp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .pending    (pending),
    .pool_used  (pool_used),
    .fail_count (fail_count)
  );

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic asp_in_t build_req(logic [1:0] kind, logic [LIFE_W-1:0] life,
                                        logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                        logic [WORD_W-1:0] s, logic [SLOT_W-1:0] slot);
    asp_in_t rq;
    rq.req_type      = kind;
    rq.lifetime      = life;
    rq.payload_x     = x;
    rq.payload_y     = y;
    rq.payload_scale = s;
    rq.read_slot     = slot;
    return rq;
  endfunction

  function automatic asp_in_t make_req(logic [1:0] kind, logic [LIFE_W-1:0] life,
                                       logic [SLOT_W-1:0] slot);
    return build_req(kind, life, rand_word(), rand_word(), rand_word(), slot);
  endfunction

  // Mostly slots in use, sometimes any index
  function automatic logic [SLOT_W-1:0] pick_slot();
    if (pool_used > 0 && $urandom_range(0, 9) < 7) return SLOT_W'($urandom_range(0, pool_used - 1));
    return SLOT_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [LIFE_W-1:0] short_life(int top);
    return LIFE_W'($urandom_range(1, top));
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until taken, then sometimes idle for a while
  task automatic send_req(asp_in_t rq);
    int pause;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    sent++;
    pause = gap_len();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random stall runs, mostly short, a few long, some quiet stretches
  initial begin : sink_stall
    int run;
    int roll;
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        out_stall <= 1'b0;
        run = $urandom_range(50, 300);
      end else if (roll < 50) begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 20);
      end else if (roll < 85) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 3);
      end else if (roll < 97) begin
        out_stall <= 1'b1;
        run = $urandom_range(4, 12);
      end else begin
        out_stall <= 1'b1;
        run = $urandom_range(20, 60);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int roll;
    int pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pool, unknown code, refill of a freed slot, emptying
    send_req(make_req(REQ_TICK, '0, '0));
    send_req(make_req(REQ_READ, '0, '0));
    send_req(make_req(REQ_READ, '0, '1));
    send_req(build_req(REQ_BAD, '1, '1, '1, '1, '1));
    send_req(build_req(REQ_ADD, LIFE_W'(1), '1, '1, '1, '0));
    send_req(build_req(REQ_ADD, LIFE_W'(2), '0, '0, '0, '1));
    send_req(make_req(REQ_READ, '0, SLOT_W'(0)));
    send_req(make_req(REQ_READ, '0, SLOT_W'(1)));
    send_req(make_req(REQ_READ, '0, SLOT_W'(2)));
    send_req(make_req(REQ_TICK, '0, '0));
    send_req(make_req(REQ_READ, '0, SLOT_W'(0)));
    send_req(make_req(REQ_ADD, LIFE_W'(1), '0));
    send_req(make_req(REQ_READ, '0, SLOT_W'(0)));
    send_req(make_req(REQ_TICK, '0, '0));
    send_req(make_req(REQ_READ, '0, SLOT_W'(1)));
    send_req(build_req(REQ_READ, '1, '1, '1, '1, '1));
    wait_quiet();

    // Random phases with short lifetimes so the pool keeps emptying
    while (sent < ITEMS - TAIL_REQS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(10, 40)) begin
          roll = $urandom_range(0, 99);
          if (roll < 50) send_req(make_req(REQ_ADD, short_life(6), pick_slot()));
          else if (roll < 75) send_req(make_req(REQ_TICK, short_life(6), pick_slot()));
          else if (roll < 97) send_req(make_req(REQ_READ, short_life(6), pick_slot()));
          else send_req(make_req(REQ_BAD, short_life(6), pick_slot()));
        end
      end else if (pick < 62) begin
        // fill past capacity, then age everything out
        repeat (70) begin
          if ($urandom_range(0, 9) == 0) send_req(make_req(REQ_READ, '0, pick_slot()));
          else send_req(make_req(REQ_ADD, short_life(8), pick_slot()));
        end
        repeat (10) begin
          send_req(make_req(REQ_TICK, '0, '0));
          if ($urandom_range(0, 1) == 0) send_req(make_req(REQ_READ, '0, pick_slot()));
        end
      end else if (pick < 77) begin
        repeat ($urandom_range(3, 10)) begin
          send_req(make_req(REQ_TICK, short_life(4), pick_slot()));
          send_req(make_req(REQ_READ, short_life(4), pick_slot()));
        end
      end else if (pick < 87) begin
        repeat ($urandom_range(8, 20)) begin
          send_req(make_req(2'($urandom_range(0, 3)), short_life(10), 6'($urandom_range(0, 63))));
        end
      end else begin
        wait_quiet();
      end
    end
    no_gaps = 1'b0;
    wait_quiet();

    // Tail: zero, largest and wide lifetimes that pin slots, then add while full
    send_req(make_req(REQ_ADD, '0, '0));
    send_req(make_req(REQ_ADD, '1, '0));
    repeat (70) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) send_req(make_req(REQ_ADD, LIFE_W'($urandom()), pick_slot()));
      else if (roll < 85) send_req(make_req(REQ_READ, LIFE_W'($urandom()), pick_slot()));
      else send_req(make_req(REQ_TICK, LIFE_W'($urandom()), pick_slot()));
    end
    repeat (10) send_req(make_req(REQ_ADD, LIFE_W'($urandom()), '0));
    repeat (10) send_req(make_req(REQ_READ, '0, pick_slot()));
    send_req(make_req(REQ_TICK, '0, '0));
    send_req(make_req(REQ_READ, '0, pick_slot()));

    // Drain and let the pipeline settle
    wait_quiet();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/asp_pkg.sv
design/asp_ram.sv
design/asp_ctrl.sv
design/aging_slot_pool.sv
tb/asp_checker.sv
tb/tb.sv
